>>> rtl/core/ppr_pkg.sv
// ============================================================================
// ppr_pkg
// Shared types, widths and constants of the pressure proportional regulator.
// ============================================================================
package ppr_pkg;

    // Field widths
    localparam int CODE_W      = 10;
    localparam int LEVEL_W     = 32;
    localparam int GAIN_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int PWM_W       = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // Shared multiplier: 33-bit signed by 17-bit signed
    localparam int MUL_A_W = LEVEL_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Wide accumulator for the pressure sum before saturation
    localparam int ACC_W = 36;

    // Parameter defaults
    localparam int ADC_BITS_DEF    = 10;
    localparam int SAVE_PERIOD_DEF = 10;

    // Constants (Q8.8 speed, Q16.16 pressure)
    localparam logic [SPEED_W-1:0]        SPEED_MAX_Q    = 16'd46080;  // 180.0
    localparam logic [PWM_W-1:0]          PWM_OFFSET     = 8'd75;
    localparam logic signed [LEVEL_W-1:0] DEAD_ZONE_LOW  = -32'sd327;  // -0.005
    localparam logic signed [LEVEL_W-1:0] REACHED_WINDOW = 32'sd655;   // 0.01
    localparam logic [GAIN_W-1:0]         SPEED_GAIN_RST = 16'd256;    // 1.0
    localparam logic [GAIN_W-1:0]         VALVE_GAIN_RST = 16'd2560;   // 10.0

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_LEVEL = 4'd0,
        REG_SPEED_GAIN   = 4'd1,
        REG_VALVE_GAIN   = 4'd2,
        REG_DUAL_MODE    = 4'd3,
        REG_UPPER_SCALE  = 4'd4,
        REG_UPPER_BASE   = 4'd5,
        REG_LOWER_SCALE  = 4'd6,
        REG_LOWER_BASE   = 4'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_U,
        ST_MUL_L,
        ST_DIFF,
        ST_MEAS,
        ST_ERR,
        ST_MAG,
        ST_MUL_V,
        ST_MUL_S,
        ST_SPEED,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] upper_code;
        logic [CODE_W-1:0] lower_code;
    } in_item_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] measured_level;
        logic signed [LEVEL_W-1:0] level_error;
        logic [SPEED_W-1:0]        speed_now;
        logic [PWM_W-1:0]          pwm_duty;
        logic signed [LEVEL_W-1:0] valve_delta;
        logic                      reached_pulse;
        logic                      save_pulse;
    } out_item_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_op_t;

endpackage

>>> rtl/core/ppr_mul.sv
// ============================================================================
// ppr_mul
// Shared signed multiplier with registered product.
// ============================================================================
module ppr_mul (
    input  logic                                 aclk,
    input  ppr_pkg::mul_op_t                     op,
    output logic signed [ppr_pkg::PROD_W-1:0]    prod
);
    import ppr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op.a * op.b);

    // product holds between operations
    always_ff @(posedge aclk) begin
        if (op.en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/pressure_proportional_regulator_top.sv
// ============================================================================
// Pressure proportional regulator
// One control tick per input transaction: both sensor ADC codes come in on
// s_item (s_valid/s_ready), one result transaction leaves on m_item
// (m_valid/m_ready) carrying measured pressure, error, motor speed, PWM duty,
// valve step request, reached flag and save flag.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high. Write only while no tick is in flight.
// Writing target_level arms the one-shot reached flag.
// A tick is run by the sequencer, which puts four products through the one
// shared multiplier plus the add/saturate steps between them; the result is
// loaded into the output register when the final step finishes.
// s_ready is high only while the sequencer is idle. The output register
// lets the next tick be accepted while a result still waits; a finished tick
// holds in the final step until the output register is free.
// Reset (aresetn low, synchronous) restores register defaults, clears motor
// speed, the reached arm and the save counter, and drops m_valid.
// ============================================================================
module pressure_proportional_regulator_top #(
    parameter int ADC_BITS    = ppr_pkg::ADC_BITS_DEF,
    parameter int SAVE_PERIOD = ppr_pkg::SAVE_PERIOD_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ppr_pkg::in_item_t                    s_item,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ppr_pkg::out_item_t                   m_item,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ppr_pkg::*;

    localparam int unsigned MASK_INT  = (1 << ADC_BITS) - 1;
    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'(MASK_INT);
    localparam int SAVE_W = $clog2(SAVE_PERIOD + 2);

    // ---------------- configuration registers ----------------
    logic signed [LEVEL_W-1:0] target_level_reg;
    logic [GAIN_W-1:0]         speed_gain_reg;
    logic [GAIN_W-1:0]         valve_gain_reg;
    logic                      dual_mode_reg;
    logic signed [LEVEL_W-1:0] upper_scale_reg;
    logic signed [LEVEL_W-1:0] upper_base_reg;
    logic signed [LEVEL_W-1:0] lower_scale_reg;
    logic signed [LEVEL_W-1:0] lower_base_reg;

    // ---------------- control state ----------------
    state_t                state_reg, state_next;
    logic [SPEED_W-1:0]    speed_reg;
    logic                  armed_reg;
    logic [SAVE_W-1:0]     save_count_reg;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    // ---------------- datapath registers ----------------
    logic [CODE_W-1:0]         ucode_reg;
    logic [CODE_W-1:0]         lcode_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [LEVEL_W-1:0] meas_reg;
    logic signed [LEVEL_W-1:0] err_reg;
    logic [LEVEL_W-1:0]        mag_reg;
    logic                      neg_reg;
    logic                      reached_reg;
    logic signed [LEVEL_W-1:0] valve_reg;

    // ---------------- shared multiplier ----------------
    mul_op_t                  mul_op;
    logic signed [PROD_W-1:0] prod;

    ppr_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (prod)
    );

    // Q8.24 * code floored to Q16.16: drop 8 LSBs, keep the signed range
    logic signed [ACC_W-1:0] prod_q16;
    assign prod_q16 = $signed(prod[ACC_W+7:8]);

    // ---------------- combinational datapath ----------------
    logic signed [ACC_W-1:0]   diff;
    logic signed [LEVEL_W-1:0] meas_sat;
    logic signed [LEVEL_W-1:0] meas_dz;
    logic signed [LEVEL_W:0]   err_wide;
    logic signed [LEVEL_W-1:0] err_sat;
    logic [LEVEL_W-1:0]        mag_calc;
    logic                      in_window;
    logic                      vsat;
    logic [LEVEL_W-2:0]        vmag;
    logic [LEVEL_W-1:0]        vmag_ext;
    logic [LEVEL_W-1:0]        step;
    logic [LEVEL_W:0]          speed_sum;
    logic [SPEED_W-1:0]        speed_calc;
    logic                      save_hit;
    logic                      out_free;

    always_comb begin
        diff = dual_mode_reg ? (acc_reg - prod_q16) : acc_reg;
        // saturate to 32 bits
        if (diff > ACC_W'(signed'(33'sd2147483647))) begin
            meas_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
        end else if (diff < -(ACC_W'(signed'(33'sd2147483647))) - ACC_W'(1)) begin
            meas_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
        end else begin
            meas_sat = diff[LEVEL_W-1:0];
        end
        // dead zone: just below zero reads as zero
        meas_dz = (meas_sat < 0 && meas_sat >= DEAD_ZONE_LOW) ? '0 : meas_sat;

        err_wide = {target_level_reg[LEVEL_W-1], target_level_reg}
                 - {meas_reg[LEVEL_W-1], meas_reg};
        if (err_wide[LEVEL_W] != err_wide[LEVEL_W-1]) begin
            err_sat = err_wide[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}}
                                        : {1'b0, {(LEVEL_W-1){1'b1}}};
        end else begin
            err_sat = err_wide[LEVEL_W-1:0];
        end

        mag_calc  = err_reg[LEVEL_W-1] ? LEVEL_W'(-err_reg) : LEVEL_W'(err_reg);
        in_window = (err_reg >= -REACHED_WINDOW) && (err_reg <= REACHED_WINDOW);

        // valve: (gain * mag) >> 8, capped at 2^31-1
        vsat     = |prod[PROD_W-1:LEVEL_W+7];
        vmag     = vsat ? '1 : prod[LEVEL_W+6:8];
        vmag_ext = {1'b0, vmag};

        // motor: (gain * mag) >> 16
        step      = prod[LEVEL_W+15:16];
        speed_sum = {1'b0, step} + (LEVEL_W+1)'(speed_reg);
        if (neg_reg) begin
            speed_calc = ({{(LEVEL_W-SPEED_W){1'b0}}, speed_reg} >= step)
                       ? SPEED_W'(speed_reg - step[SPEED_W-1:0]) : '0;
        end else begin
            speed_calc = (speed_sum > (LEVEL_W+1)'(SPEED_MAX_Q))
                       ? SPEED_MAX_Q : speed_sum[SPEED_W-1:0];
        end

        save_hit = save_count_reg > SAVE_W'(SAVE_PERIOD);
        out_free = !m_valid_reg || m_ready;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_op     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL_U;
            end
            ST_MUL_U: begin
                mul_op.en  = 1'b1;
                mul_op.a   = MUL_A_W'(upper_scale_reg);
                mul_op.b   = MUL_B_W'(ucode_reg);
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                mul_op.en  = 1'b1;
                mul_op.a   = MUL_A_W'(lower_scale_reg);
                mul_op.b   = MUL_B_W'(lcode_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_MEAS;
            ST_MEAS:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_MUL_V;
            ST_MUL_V: begin
                mul_op.en  = 1'b1;
                mul_op.a   = MUL_A_W'(mag_reg);
                mul_op.b   = MUL_B_W'(valve_gain_reg);
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                mul_op.en  = 1'b1;
                mul_op.a   = MUL_A_W'(mag_reg);
                mul_op.b   = MUL_B_W'(speed_gain_reg);
                state_next = ST_SPEED;
            end
            ST_SPEED: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ucode_reg <= s_item.upper_code & CODE_MASK;
                lcode_reg <= s_item.lower_code & CODE_MASK;
            end
            ST_MUL_L: acc_reg  <= prod_q16 + ACC_W'(upper_base_reg);
            ST_DIFF: begin
                if (dual_mode_reg) acc_reg <= acc_reg - ACC_W'(lower_base_reg);
            end
            ST_MEAS:  meas_reg <= meas_dz;
            ST_ERR:   err_reg  <= err_sat;
            ST_MAG: begin
                mag_reg     <= mag_calc;
                neg_reg     <= err_reg[LEVEL_W-1];
                reached_reg <= armed_reg && in_window;
            end
            ST_MUL_S: valve_reg <= neg_reg ? $signed(vmag_ext) : -$signed(vmag_ext);
            default: ;
        endcase
    end

    // ---------------- state kept across ticks, config ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_level_reg <= '0;
            speed_gain_reg   <= SPEED_GAIN_RST;
            valve_gain_reg   <= VALVE_GAIN_RST;
            dual_mode_reg    <= 1'b0;
            upper_scale_reg  <= '0;
            upper_base_reg   <= '0;
            lower_scale_reg  <= '0;
            lower_base_reg   <= '0;
            speed_reg        <= '0;
            armed_reg        <= 1'b0;
            save_count_reg   <= '0;
        end else begin
            if (state_reg == ST_MAG && in_window) armed_reg <= 1'b0;
            if (state_reg == ST_SPEED) speed_reg <= speed_calc;
            if (state_reg == ST_DONE && out_free) begin
                save_count_reg <= save_hit ? SAVE_W'(1) : SAVE_W'(save_count_reg + 1'b1);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TARGET_LEVEL: begin
                        target_level_reg <= $signed(cfg_data);
                        armed_reg        <= 1'b1;
                    end
                    REG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_VALVE_GAIN:  valve_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DUAL_MODE:   dual_mode_reg   <= cfg_data[0];
                    REG_UPPER_SCALE: upper_scale_reg <= $signed(cfg_data);
                    REG_UPPER_BASE:  upper_base_reg  <= $signed(cfg_data);
                    REG_LOWER_SCALE: lower_scale_reg <= $signed(cfg_data);
                    REG_LOWER_BASE:  lower_base_reg  <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_item_reg.measured_level <= meas_reg;
            m_item_reg.level_error    <= err_reg;
            m_item_reg.speed_now      <= speed_reg;
            m_item_reg.pwm_duty       <= (speed_reg != '0)
                                       ? PWM_W'(speed_reg[SPEED_W-1:8] + PWM_OFFSET) : '0;
            m_item_reg.valve_delta    <= valve_reg;
            m_item_reg.reached_pulse  <= reached_reg;
            m_item_reg.save_pulse     <= save_hit;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // ---------------- assertions ----------------
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        speed_reg <= SPEED_MAX_Q)
        else $error("motor speed above limit");

    a_pwm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.speed_now == '0) == (m_item.pwm_duty == '0)))
        else $error("pwm duty zero does not track speed zero");

    a_reached_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.reached_pulse) |->
            (m_item.level_error >= -REACHED_WINDOW && m_item.level_error <= REACHED_WINDOW))
        else $error("reached flag outside window");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again while busy");

    a_save_count: assert property (@(posedge aclk) disable iff (!aresetn)
        save_count_reg <= SAVE_W'(SAVE_PERIOD + 1))
        else $error("save counter out of range");

endmodule
